// ===== design/rkc_pkg.sv =====
// Shared constants and types for the rotor keyed byte cipher.
`default_nettype none
package rkc_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 2'd2;

  localparam logic [1:0] DIR_PASS    = 2'd0;
  localparam logic [1:0] DIR_ENCRYPT = 2'd1;
  localparam logic [1:0] DIR_DECRYPT = 2'd2;

  localparam logic MODE_DATA    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  localparam logic [7:0] STEP_SMALL_INIT = 8'd1;
  localparam logic [3:0] STEP_LARGE_INIT = 4'd1;
  localparam logic [3:0] KEY_LENGTH_INIT = 4'd8;

  typedef struct packed {
    logic [LEN_W-1:0] key_length;
    logic [1:0]       direction;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/rkc_item_if.sv =====
// Input item channel: mode and data byte with valid/ready.
`default_nettype none
interface rkc_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== design/rkc_result_if.sv =====
// Result item channel: processed byte with valid/ready.
`default_nettype none
interface rkc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface
`default_nettype wire

// ===== design/rkc_cfg.sv =====
// Configuration registers with effective key length clamp.
`default_nettype none
module rkc_cfg
  import rkc_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output      logic [8*KEY_BYTES-1:0] key,
  output      cfg_t                   cfg
);

  logic [LEN_W-1:0] key_length;
  logic [1:0]       direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      key        <= '0;
      key_length <= KEY_LENGTH_INIT;
      direction  <= DIR_PASS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_BYTES:  key        <= cfg_data[8*KEY_BYTES-1:0];
        REG_KEY_LENGTH: key_length <= cfg_data[LEN_W-1:0];
        REG_DIRECTION:  direction  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.direction = direction;
    if (key_length == '0) begin
      cfg.key_length = LEN_W'(1);
    end else if (key_length > LEN_W'(KEY_BYTES)) begin
      cfg.key_length = LEN_W'(KEY_BYTES);
    end else begin
      cfg.key_length = key_length;
    end
  end

endmodule
`default_nettype wire

// ===== design/rkc_core.sv =====
// Keystream state, rotor stepping and byte add/subtract.
`default_nettype none
module rkc_core
  import rkc_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire logic                   mode,
  input  wire logic [7:0]             data_byte,
  input  wire logic [8*KEY_BYTES-1:0] key,
  input  wire cfg_t                   cfg,
  output      logic [7:0]             result_byte
);

  logic [7:0]       step_small,  step_small_next;
  logic [3:0]       step_large,  step_large_next;
  logic [7:0]       rotor,       rotor_next;
  logic [POS_W-1:0] key_position, key_position_next;

  logic [7:0] ks;
  logic [7:0] rotor_shift;
  logic [7:0] byte_at_pos;
  logic       active;
  logic       wrap;

  assign active = (cfg.direction == DIR_ENCRYPT) || (cfg.direction == DIR_DECRYPT);
  assign ks     = step_small + {step_large, 4'h0};

  always_comb begin
    byte_at_pos = 8'h00;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (key_position == POS_W'(i)) begin
        byte_at_pos = key[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (cfg.direction == DIR_ENCRYPT) begin
      result_byte = data_byte + ks;
    end else if (cfg.direction == DIR_DECRYPT) begin
      result_byte = data_byte - ks;
    end else begin
      result_byte = data_byte;
    end
  end

  assign rotor_shift = rotor >> 2;
  assign wrap = (key_position >= cfg.key_length) || (byte_at_pos == 8'h00);

  always_comb begin
    step_small_next   = step_small;
    step_large_next   = step_large;
    rotor_next        = rotor;
    key_position_next = key_position;
    if (mode == MODE_RESTART) begin
      step_small_next   = STEP_SMALL_INIT;
      step_large_next   = STEP_LARGE_INIT;
      rotor_next        = key[7:0];
      key_position_next = POS_W'(1);
    end else if (active) begin
      step_small_next = rotor[0] ? step_small + 8'd1 : step_small - 8'd1;
      step_large_next = rotor[1] ? step_large + 4'd1 : step_large - 4'd1;
      rotor_next      = rotor_shift;
      if (rotor_shift == 8'h00) begin
        // reload from the key, wrap to byte zero at the end or at a zero byte
        if (wrap) begin
          rotor_next        = key[7:0];
          key_position_next = POS_W'(1);
        end else begin
          rotor_next        = byte_at_pos;
          key_position_next = key_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_small   <= STEP_SMALL_INIT;
      step_large   <= STEP_LARGE_INIT;
      rotor        <= '0;
      key_position <= '0;
    end else if (fire) begin
      step_small   <= step_small_next;
      step_large   <= step_large_next;
      rotor        <= rotor_next;
      key_position <= key_position_next;
    end
  end

  a_restart_loads: assert property (@(posedge clk) disable iff (rst)
    fire && mode == MODE_RESTART |=> step_small == STEP_SMALL_INIT
      && step_large == STEP_LARGE_INIT && key_position == POS_W'(1))
    else $error("restart did not reload the keystream");

  a_pass_holds: assert property (@(posedge clk) disable iff (rst)
    fire && mode == MODE_DATA && !active |=> $stable(step_small)
      && $stable(step_large) && $stable(rotor) && $stable(key_position))
    else $error("keystream state moved in pass through");

  a_rotor_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && mode == MODE_DATA && active |=> rotor != 8'h00 || $past(key[7:0]) == 8'h00)
    else $error("rotor left empty after a step");

endmodule
`default_nettype wire

// ===== design/rotor_keyed_byte_cipher.sv =====
// Top level of the rotor keyed byte cipher: input register, core and result register.
// A data item's result is registered in the result register when the core fires.
// One item per cycle unless results stall; each ciphered item steps the keystream.
// A restart item gives no result and never waits on the result register.
// Reset (synchronous, active high) clears the registers to key 0, length 8,
// direction pass, and the keystream to rx 1, ry 16, rotor 0, position 0.
`default_nettype none
module rotor_keyed_byte_cipher
  import rkc_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  rkc_item_if.sink                    items,
  rkc_result_if.source                results,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [8*KEY_BYTES-1:0] key;
  cfg_t                   cfg;

  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_data;
  logic       fire;
  logic       out_valid;
  logic [7:0] out_result;
  logic [7:0] core_result;

  rkc_cfg #(.KEY_BYTES(KEY_BYTES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .cfg       (cfg)
  );

  rkc_core #(.KEY_BYTES(KEY_BYTES)) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .mode        (s1_mode),
    .data_byte   (s1_data),
    .key         (key),
    .cfg         (cfg),
    .result_byte (core_result)
  );

  assign fire = s1_valid && (s1_mode == MODE_RESTART || !out_valid || results.ready);
  assign items.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_mode <= items.mode;
      s1_data <= items.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_mode == MODE_DATA) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_mode == MODE_DATA) begin
      out_result <= core_result;
    end
  end

  assign results.valid       = out_valid;
  assign results.result_byte = out_result;

  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && s1_mode == MODE_DATA |=> out_valid)
    else $error("data item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |-> !(fire && s1_mode == MODE_DATA))
    else $error("stalled result overwritten");

  a_restart_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_mode == MODE_RESTART |-> fire)
    else $error("restart item held by result stall");

endmodule
`default_nettype wire

// ===== sim/tb_rotor_keyed_byte_cipher.sv =====
// Self-checking testbench for rotor_keyed_byte_cipher: directed table, then random phases.
`timescale 1ns / 100ps
module tb_rotor_keyed_byte_cipher;
  import rkc_pkg::*;

  localparam logic [1:0] DIR_UNUSED = 2'd3;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 70;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   mode;
    logic [7:0]             data;
    logic                   typed;
    logic [7:0]             want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rkc_item_if items_ch ();
  rkc_result_if results_ch ();

  rotor_keyed_byte_cipher #(
    .KEY_BYTES(8)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch.sink),
    .results(results_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // keystream and register copies
  logic [CFG_DATA_W-1:0] key_bytes_r = '0;
  logic [LEN_W-1:0] key_len_r = KEY_LENGTH_INIT;
  logic [1:0] dir_r = DIR_PASS;
  logic [7:0] ks_small = STEP_SMALL_INIT;
  logic [3:0] ks_large = STEP_LARGE_INIT;
  logic [7:0] rotor = 8'd0;
  logic [POS_W-1:0] key_pos = '0;

  logic [7:0] cipher_out_q[$];
  plan_row_t plan[$];
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned restarts = 0;
  int unsigned bytes_out = 0;
  int unsigned sink_hold = 0;
  bit idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t, %0d byte(s) still awaited", $time, cipher_out_q.size());
    $display("FAIL rotor_keyed_byte_cipher");
    $finish;
  end

  function automatic void cipher_advance(input logic m, input logic [7:0] d,
                                         output logic has, output logic [7:0] q);
    logic [7:0] ks;
    int unsigned span;
    has = 1'b0;
    q = d;
    span = (key_len_r == 0) ? 1 : (key_len_r > 8) ? 8 : key_len_r;
    if (m == MODE_RESTART) begin
      ks_small = STEP_SMALL_INIT;
      ks_large = STEP_LARGE_INIT;
      rotor = key_bytes_r[7:0];
      key_pos = 4'd1;
    end else begin
      has = 1'b1;
      if (dir_r == DIR_ENCRYPT || dir_r == DIR_DECRYPT) begin
        ks = ks_small + {ks_large, 4'b0000};
        q = (dir_r == DIR_ENCRYPT) ? d + ks : d - ks;
        ks_small = rotor[0] ? ks_small + 8'd1 : ks_small - 8'd1;
        ks_large = rotor[1] ? ks_large + 4'd1 : ks_large - 4'd1;
        rotor = rotor >> 2;
        if (rotor == 8'd0) begin
          if (key_pos >= span || key_bytes_r[8*key_pos[2:0] +: 8] == 8'd0) key_pos = '0;
          rotor = key_bytes_r[8*key_pos[2:0] +: 8];
          key_pos = key_pos + 4'd1;
        end
      end
    end
  endfunction

  task automatic send_item(input logic m, input logic [7:0] d,
                           input logic typed, input logic [7:0] want);
    logic has;
    logic [7:0] q;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.mode <= m;
    items_ch.data_byte <= d;
    do @(posedge clk); while (!items_ch.ready);
    cipher_advance(m, d, has, q);
    if (has) begin
      cipher_out_q.push_back(typed ? want : q);
      bytes_in++;
    end else begin
      restarts++;
    end
  endtask

  // drain, then allow for a restart item still in flight
  task automatic wait_idle();
    items_ch.valid <= 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_BYTES: key_bytes_r = val;
      REG_KEY_LENGTH: key_len_r = val[LEN_W-1:0];
      REG_DIRECTION: dir_r = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold--;
    end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 4);
    end
    results_ch.ready <= (sink_hold == 0);
  end

  always @(posedge clk) begin : result_check
    logic [7:0] want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      bytes_out++;
      if (cipher_out_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result_byte, expected none, actual %02h",
                 $time, results_ch.result_byte);
      end else begin
        want = cipher_out_q.pop_front();
        if (results_ch.result_byte !== want) begin
          errors++;
          $display("%0t: result_byte mismatch, expected %02h, actual %02h",
                   $time, want, results_ch.result_byte);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] key;
    logic [7:0] d;
    int unsigned r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_ch.valid = 1'b0;
    items_ch.mode = MODE_DATA;
    items_ch.data_byte = 8'd0;

    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h00, 1'b1, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'hff, 1'b1, 8'hff});
    plan.push_back('{ROW_CFG, REG_DIRECTION, 64'(DIR_UNUSED), MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h5a, 1'b1, 8'h5a});
    plan.push_back('{ROW_CFG, REG_DIRECTION, 64'(DIR_ENCRYPT), MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h00, 1'b1, 8'h11});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'hff, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_BYTES, 64'h0000_0000_0000_ff00, MODE_DATA, 8'h00, 1'b0,
                     8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_RESTART, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h80, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h7f, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_BYTES, 64'hffff_ffff_ffff_ffff, MODE_DATA, 8'h00, 1'b0,
                     8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_LENGTH, 64'd1, MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_RESTART, 8'hff, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'hff, 1'b1, 8'h10});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h01, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h80, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h55, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_LENGTH, 64'd0, MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_BYTES, 64'h0102_0408_1020_4080, MODE_DATA, 8'h00, 1'b0,
                     8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_RESTART, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'haa, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h33, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'hcc, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_KEY_LENGTH, 64'd15, MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_CFG, REG_DIRECTION, 64'(DIR_DECRYPT), MODE_DATA, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_RESTART, 8'h00, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h00, 1'b1, 8'hef});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'hff, 1'b0, 8'h00});
    plan.push_back('{ROW_ITEM, REG_KEY_BYTES, 64'd0, MODE_DATA, 8'h0f, 1'b0, 8'h00});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].mode, plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      idle_on = (p < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: key = '1;
        1: key = '0;
        2: key = {$urandom, $urandom};
        3: begin
          key = {$urandom, $urandom};
          for (int b = 0; b < 8; b++) if ($urandom_range(0, 2) == 0) key[8*b +: 8] = 8'd0;
        end
        default: key = {$urandom, $urandom} & ~64'hff;
      endcase
      write_reg(REG_KEY_BYTES, key);
      write_reg(REG_KEY_LENGTH, 64'($urandom_range(0, 15)));
      r = $urandom_range(0, 9);
      write_reg(REG_DIRECTION, 64'((r == 0) ? DIR_PASS : (r == 1) ? DIR_UNUSED :
                                   (r < 6) ? DIR_ENCRYPT : DIR_DECRYPT));
      if ($urandom_range(0, 3) != 0) send_item(MODE_RESTART, 8'($urandom), 1'b0, 8'h00);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        d = 8'($urandom);
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 15) == 0) send_item(MODE_RESTART, d, 1'b0, 8'h00);
        else send_item(MODE_DATA, d, 1'b0, 8'h00);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d data bytes and %0d restarts over %0d random phases",
             bytes_in, restarts, N_PHASES);
    $display("%0d result bytes checked, %0d mismatch(es)", bytes_out, errors);
    if (errors == 0) begin
      $display("PASS rotor_keyed_byte_cipher");
    end else begin
      $display("FAIL rotor_keyed_byte_cipher");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rkc_pkg.sv
design/rkc_item_if.sv
design/rkc_result_if.sv
design/rkc_cfg.sv
design/rkc_core.sv
design/rotor_keyed_byte_cipher.sv
sim/tb_rotor_keyed_byte_cipher.sv
